/* design/psrg_pkg.sv */
// Shared constants and types for the per-axis scale ramp generator.
`timescale 1ns / 1ps
package psrg_pkg;
   localparam int unsigned NUM_AXES_DEFAULT = 3;
   localparam int unsigned LEVEL_W = 32;
   localparam int unsigned FRAME_W = 16;
   localparam int unsigned SWEEP_W = 17;
   localparam int unsigned FUNC_W = 3;
   localparam int unsigned SEL_W = 2;
   localparam int unsigned REQ_DATA_W = 136;
   localparam int unsigned REQ_USER_W = 5;
   localparam int unsigned RSP_DATA_W = 104;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [LEVEL_W-1:0] RESET_LEVEL = 32'd1000;
   localparam logic [LEVEL_W-1:0] RESET_TOP = 32'd1000000;
   localparam logic [LEVEL_W-1:0] RESET_BOTTOM = 32'd1000;

   localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_TIMED = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEPPED = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ACCEL = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_BOUNCE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STOP = 3'd5;

   localparam logic [SEL_W-1:0] SEL_ALL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM = 1'd1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_ACCEL = 2'd2,
      MODE_BOUNCE = 2'd3
   } mode_type;

   typedef struct packed {
      logic start;
      logic [LEVEL_W-1:0] dividend;
      logic [FRAME_W-1:0] divisor;
   } div_req_type;
endpackage

/* design/psrg_divider.sv */
// Iterative signed-by-unsigned truncating divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psrg_divider (
   input  logic clock,
   input  logic reset,
   input  psrg_pkg::div_req_type div_req,
   output logic done,
   output logic [psrg_pkg::LEVEL_W-1:0] quotient
);
   import psrg_pkg::*;

   localparam int unsigned CNT_W = $clog2(LEVEL_W + 1);

   logic busy_ff;
   logic done_ff;
   logic neg_ff;
   logic [CNT_W-1:0] count_ff;
   logic [LEVEL_W-1:0] mag_ff;
   logic [FRAME_W-1:0] rem_ff;
   logic [FRAME_W-1:0] dsr_ff;
   logic [FRAME_W:0] trial;
   logic fits;

   assign trial = {rem_ff, mag_ff[LEVEL_W-1]};
   assign fits = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            count_ff <= CNT_W'(LEVEL_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         neg_ff <= div_req.dividend[LEVEL_W-1];
         mag_ff <= div_req.dividend[LEVEL_W-1] ? (~div_req.dividend + 1'b1)
                                               : div_req.dividend;
         rem_ff <= '0;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? FRAME_W'(trial - {1'b0, dsr_ff}) : trial[FRAME_W-1:0];
         mag_ff <= {mag_ff[LEVEL_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (~mag_ff + 1'b1) : mag_ff;
endmodule

/* design/per_axis_scale_ramp_generator_top.sv */
// Top level of the per-axis scale ramp generator: sequencer, axis state and ports.
`timescale 1ns / 1ps
// Each transfer is a tick or a command and yields one result transfer holding every
// axis level and the active mask. The sequencer visits the axes one after another,
// through states EVAL and NEXT, and waits on the shared divider for each axis that
// arms a timed ramp or a bounce, or turns a bounce on a tick. No new item is taken
// while one is being worked on.
module per_axis_scale_ramp_generator_top #(
   parameter int unsigned NUM_AXES = psrg_pkg::NUM_AXES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // target_level[31:0], frame_count[47:32], step_value[79:48], accel_value[111:80],
   // half_sweeps[128:112], zero fill above
   input  logic [psrg_pkg::REQ_DATA_W-1:0] req_tdata,
   // func[2:0], axis_select[4:3]
   input  logic [psrg_pkg::REQ_USER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // scale_x[31:0], scale_y[63:32], scale_z[95:64], active_axes[98:96], zero fill above
   output logic [psrg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [psrg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [psrg_pkg::LEVEL_W-1:0] csr_wdata
);
   import psrg_pkg::*;

   localparam int unsigned AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_DIV = 3'd2;
   localparam logic [2:0] S_NEXT = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   logic [2:0] state_ff;
   logic [AX_W-1:0] ax_ff;
   logic [LEVEL_W-1:0] top_ff, bottom_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [SEL_W-1:0] sel_ff;
   logic [LEVEL_W-1:0] tgt_ff, stepv_ff, accv_ff;
   logic [FRAME_W-1:0] frames_ff;
   logic [SWEEP_W-1:0] half_ff;
   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic div_fb_ff;
   logic [LEVEL_W-1:0] div_gap_ff;

   logic [LEVEL_W-1:0] level_ff [NUM_AXES];
   logic [LEVEL_W-1:0] step_ff [NUM_AXES];
   logic [LEVEL_W-1:0] goal_ff [NUM_AXES];
   logic [LEVEL_W-1:0] accel_ff [NUM_AXES];
   mode_type mode_ff [NUM_AXES];
   logic [SWEEP_W-1:0] count_ff [NUM_AXES];
   logic [SWEEP_W-1:0] limit_ff [NUM_AXES];
   logic [FRAME_W-1:0] period_ff [NUM_AXES];

   logic [LEVEL_W-1:0] level_in, step_in, goal_in, accel_in;
   mode_type mode_in;
   logic [SWEEP_W-1:0] count_in, limit_in;
   logic [FRAME_W-1:0] period_in;
   logic need_div, fb_in;
   logic [LEVEL_W-1:0] gap_in;
   div_req_type div_req;
   logic div_done;
   logic [LEVEL_W-1:0] div_q;

   logic [LEVEL_W-1:0] cur_level, cur_step, sum, span2, gap;
   logic [FRAME_W-1:0] dsr_raw, half_frames;
   logic [SWEEP_W-1:0] next_count;
   logic selected, req_accept, rsp_load;
   logic [2:0] act;
   logic [LEVEL_W-1:0] scale [3];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   assign cur_level = level_ff[ax_ff];
   assign cur_step = step_ff[ax_ff];
   assign sum = cur_level + cur_step;
   assign span2 = (top_ff - bottom_ff) << 1;
   assign half_frames = frames_ff >> 1;
   assign next_count = count_ff[ax_ff] + 1'b1;
   assign selected = (sel_ff == SEL_ALL) || (32'(sel_ff) == 32'(ax_ff));

   always_comb begin
      level_in = cur_level;
      step_in = cur_step;
      goal_in = goal_ff[ax_ff];
      accel_in = accel_ff[ax_ff];
      mode_in = mode_ff[ax_ff];
      count_in = count_ff[ax_ff];
      limit_in = limit_ff[ax_ff];
      period_in = period_ff[ax_ff];
      need_div = 1'b0;
      fb_in = 1'b0;
      gap = tgt_ff - cur_level;
      gap_in = gap;
      dsr_raw = frames_ff;
      if (func_ff == FUNC_TICK) begin
         if (mode_ff[ax_ff] == MODE_BOUNCE) begin
            level_in = sum;
            if ($signed(top_ff) <= $signed(sum) || $signed(bottom_ff) >= $signed(sum)) begin
               need_div = 1'b1;
               dsr_raw = period_ff[ax_ff];
               count_in = next_count;
               if (!limit_ff[ax_ff][SWEEP_W-1] && next_count == limit_ff[ax_ff]) begin
                  mode_in = MODE_IDLE;
               end
               if ($signed(top_ff) <= $signed(sum)) begin
                  level_in = top_ff;
                  gap_in = ~span2 + 1'b1;
               end else begin
                  level_in = bottom_ff;
                  gap_in = span2;
               end
            end
         end else if (mode_ff[ax_ff] != MODE_IDLE) begin
            level_in = sum;
            if (($signed(cur_step) > 0 && $signed(goal_ff[ax_ff]) <= $signed(sum)) ||
                ($signed(cur_step) < 0 && $signed(goal_ff[ax_ff]) >= $signed(sum))) begin
               level_in = goal_ff[ax_ff];
               mode_in = MODE_IDLE;
            end
            if (mode_ff[ax_ff] == MODE_ACCEL) begin
               step_in = cur_step + accel_ff[ax_ff];
            end
         end
      end else if (selected) begin
         case (func_ff)
            FUNC_TIMED: begin
               mode_in = MODE_LINEAR;
               goal_in = tgt_ff;
               need_div = 1'b1;
               fb_in = 1'b1;
            end
            FUNC_STEPPED: begin
               mode_in = MODE_LINEAR;
               goal_in = tgt_ff;
               if (gap == '0) begin
                  step_in = '0;
               end else if (gap[LEVEL_W-1]) begin
                  step_in = ~stepv_ff + 1'b1;
               end else begin
                  step_in = stepv_ff;
               end
            end
            FUNC_ACCEL: begin
               mode_in = MODE_ACCEL;
               goal_in = tgt_ff;
               step_in = stepv_ff;
               accel_in = accv_ff;
            end
            FUNC_BOUNCE: begin
               mode_in = MODE_BOUNCE;
               count_in = '0;
               limit_in = half_ff;
               period_in = frames_ff;
               gap_in = top_ff - cur_level;
               dsr_raw = half_frames;
               need_div = 1'b1;
               fb_in = 1'b1;
            end
            FUNC_STOP: mode_in = MODE_IDLE;
            default: ;
         endcase
      end
   end

   assign div_req.start = (state_ff == S_EVAL) && need_div;
   assign div_req.dividend = gap_in;
   assign div_req.divisor = (dsr_raw == '0) ? FRAME_W'(1) : dsr_raw;

   psrg_divider u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .done(div_done),
      .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff <= '0;
         rsp_valid_ff <= 1'b0;
         top_ff <= RESET_TOP;
         bottom_ff <= RESET_BOTTOM;
         for (int i = 0; i < NUM_AXES; i++) begin
            level_ff[i] <= RESET_LEVEL;
            step_ff[i] <= '0;
            goal_ff[i] <= RESET_LEVEL;
            accel_ff[i] <= '0;
            mode_ff[i] <= MODE_IDLE;
            count_ff[i] <= '0;
            limit_ff[i] <= '1;
            period_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TOP: top_ff <= csr_wdata;
               CSR_BOTTOM: bottom_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  ax_ff <= '0;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               level_ff[ax_ff] <= level_in;
               step_ff[ax_ff] <= step_in;
               goal_ff[ax_ff] <= goal_in;
               accel_ff[ax_ff] <= accel_in;
               mode_ff[ax_ff] <= mode_in;
               count_ff[ax_ff] <= count_in;
               limit_ff[ax_ff] <= limit_in;
               period_ff[ax_ff] <= period_in;
               state_ff <= need_div ? S_DIV : S_NEXT;
            end
            S_DIV: begin
               if (div_done) begin
                  step_ff[ax_ff] <= (div_fb_ff && div_q == '0) ? div_gap_ff : div_q;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (32'(ax_ff) == NUM_AXES - 1) begin
                  state_ff <= S_OUT;
               end else begin
                  ax_ff <= ax_ff + 1'b1;
                  state_ff <= S_EVAL;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_tuser[FUNC_W-1:0];
         sel_ff <= req_tuser[FUNC_W+SEL_W-1:FUNC_W];
         tgt_ff <= req_tdata[31:0];
         frames_ff <= req_tdata[47:32];
         stepv_ff <= req_tdata[79:48];
         accv_ff <= req_tdata[111:80];
         half_ff <= req_tdata[128:112];
      end
      if (div_req.start) begin
         div_fb_ff <= fb_in;
         div_gap_ff <= gap_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= {5'd0, act, scale[2], scale[1], scale[0]};
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_out
      if (g < NUM_AXES) begin : g_have
         assign scale[g] = level_ff[g];
         assign act[g] = (mode_ff[g] != MODE_IDLE);
      end else begin : g_none
         assign scale[g] = '0;
         assign act[g] = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule
